FILE: src/pid_pkg.sv
`default_nettype none
package pid_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_BITS = 16;
    localparam int GAIN_W     = 24;
    localparam int OPND_W     = 33;
    localparam int ACC_W      = OPND_W + 1 + GAIN_W;
    localparam int MUL_STEPS  = GAIN_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_SUM
    } t_state_core;

    typedef enum logic [2:0] {
        S_IDLE_T,
        S_LOAD_T,
        S_MUL_T,
        S_SUM_T,
        S_OUT_T
    } t_state;

    typedef enum logic [1:0] {
        OP_P,
        OP_I,
        OP_D,
        OP_F
    } t_op;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_D_ALPHA,
        REG_OUT_LIM,
        REG_INT_LIM,
        REG_NONE
    } t_reg;

    localparam logic CMD_RUN   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = ACC_W'(64'sh7FFF_FFFF);
            lo = -hi - ACC_W'(1);
            if (v > hi) begin
                sat32 = 32'sh7FFF_FFFF;
            end else if (v < lo) begin
                sat32 = 32'sh8000_0000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

    function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                     input logic [33:0] lim);
        logic signed [34:0] vx;
        logic signed [34:0] lx;
        begin
            vx = 35'(v);
            lx = $signed({1'b0, lim});
            if (lim == 34'd0) begin
                clamp_sym = v;
            end else if (vx > lx) begin
                clamp_sym = lx[31:0];
            end else if (vx < -lx) begin
                clamp_sym = (-lx) >>> 0 == 35'sd0 ? 32'sd0 : 32'((-lx));
            end else begin
                clamp_sym = v;
            end
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/pid_controller_dual_form.sv
// Each accepted transaction runs load and multiply for the P, I, D and filter products in
// turn, then sum and output; a clear command goes straight to output. A result is offered
// once the output register is free. Only one transaction is in work at a time, set by the
// single shared bit-serial multiplier that computes each of the P, I, D and filter products.
// A new transaction is taken while the previous result waits in the output register.
// Reset (synchronous, active low) zeroes all kept state and restores register defaults.
`default_nettype none
module pid_controller_dual_form (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_cmd,
    input  wire logic signed [15:0] i_target,
    input  wire logic signed [15:0] i_feedback,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_drive,
    output logic signed [31:0]      o_p_term,
    output logic signed [31:0]      o_i_term,
    output logic signed [31:0]      o_d_term,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int AW = pid_pkg::ACC_W;
    localparam int OW = pid_pkg::OPND_W;
    localparam int GW = pid_pkg::GAIN_W;

    // configuration
    logic                r_mode;
    logic signed [23:0]  r_gain_p, r_gain_i, r_gain_d;
    logic [16:0]         r_alpha;
    logic [30:0]         r_olim, r_ilim;

    // kept state
    logic signed [16:0]  r_prev_err, r_prev2_err;
    logic signed [31:0]  r_esum, r_prev_d, r_held;

    // work registers
    pid_pkg::t_state     r_state, n_state;
    pid_pkg::t_op        r_op;
    logic [4:0]          r_cnt;
    logic signed [OW-1:0] r_e1, r_e2, r_e3, r_mcand;
    logic signed [AW-1:0] r_acc;
    logic signed [31:0]  r_p, r_i, r_raw, r_d, r_o;

    logic in_acc, out_free, cfg_wr, mul_last;
    logic [2:0] cfg_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = paddr[4:2];
    assign in_acc   = i_valid & ~o_stall;
    assign out_free = ~o_valid | ~i_stall;
    assign mul_last = (r_cnt == 5'(pid_pkg::MUL_STEPS - 1));

    always_comb begin
        case (pid_pkg::t_reg'(cfg_idx))
            pid_pkg::REG_MODE:    prdata = {31'd0, r_mode};
            pid_pkg::REG_GAIN_P:  prdata = 32'(r_gain_p);
            pid_pkg::REG_GAIN_I:  prdata = 32'(r_gain_i);
            pid_pkg::REG_GAIN_D:  prdata = 32'(r_gain_d);
            pid_pkg::REG_D_ALPHA: prdata = {15'd0, r_alpha};
            pid_pkg::REG_OUT_LIM: prdata = {1'b0, r_olim};
            pid_pkg::REG_INT_LIM: prdata = {1'b0, r_ilim};
            default:              prdata = 32'd0;
        endcase
    end

    // error and running sum, taken at acceptance (the sum only when r_mode is 0)
    logic signed [16:0] err;
    logic signed [33:0] esum_raw;
    logic signed [31:0] esum_sat, esum_new;
    logic [30:0]        olim_int;
    logic [33:0]        ilim_der, ilim;

    assign err      = 17'(i_target) - 17'(i_feedback);
    assign esum_raw = 34'(r_esum) + 34'(err);
    assign esum_sat = pid_pkg::sat32(AW'(esum_raw));
    assign olim_int = r_olim >> pid_pkg::FRAC_BITS;
    assign ilim_der = ({3'd0, olim_int} * 34'd7) >> 1;
    assign ilim     = (r_ilim != 31'd0) ? {3'd0, r_ilim} : ilim_der;
    assign esum_new = pid_pkg::clamp_sym(esum_sat, ilim);

    // one multiplier bit per cycle; the top bit carries negative weight
    logic signed [OW:0]   addend, hi_n;
    logic signed [AW-1:0] prod;
    assign addend = r_acc[0] ? (OW+1)'(r_mcand) : '0;
    assign hi_n   = mul_last ? (r_acc[AW-1:GW] - addend) : (r_acc[AW-1:GW] + addend);
    assign prod   = {hi_n[OW], hi_n, r_acc[GW-1:1]};

    // filter product: prev_d + floor(alpha*(raw-prev_d) / 2^16), or raw when alpha bit 16 is set
    logic signed [AW-1:0] filt_sum;
    logic signed [31:0]   d_new;
    assign filt_sum = AW'(r_prev_d) + (prod >>> pid_pkg::ALPHA_BITS);
    always_comb begin
        if (r_alpha == 17'd0) begin
            d_new = r_prev_d;
        end else if (r_alpha[16]) begin
            d_new = r_raw;
        end else begin
            d_new = pid_pkg::sat32(filt_sum);
        end
    end

    // output sum
    logic signed [31:0] s_pid, o_pre, o_new;
    assign s_pid = pid_pkg::sat32(AW'(r_p) + AW'(r_i) + AW'(r_d));
    assign o_pre = r_mode ? pid_pkg::sat32(AW'(r_held) + AW'(s_pid)) : s_pid;
    assign o_new = pid_pkg::clamp_sym(o_pre, {3'd0, r_olim});

    always_comb begin
        n_state = r_state;
        case (r_state)
            pid_pkg::S_IDLE_T: begin
                if (in_acc) begin
                    n_state = (i_cmd == pid_pkg::CMD_CLEAR) ? pid_pkg::S_OUT_T
                                                            : pid_pkg::S_LOAD_T;
                end
            end
            pid_pkg::S_LOAD_T: n_state = pid_pkg::S_MUL_T;
            pid_pkg::S_MUL_T: begin
                if (mul_last) begin
                    n_state = (r_op == pid_pkg::OP_F) ? pid_pkg::S_SUM_T : pid_pkg::S_LOAD_T;
                end
            end
            pid_pkg::S_SUM_T: n_state = pid_pkg::S_OUT_T;
            pid_pkg::S_OUT_T: begin
                if (out_free) begin
                    n_state = pid_pkg::S_IDLE_T;
                end
            end
            default: n_state = pid_pkg::S_IDLE_T;
        endcase
    end

    always_comb begin
        case (r_state)
            pid_pkg::S_IDLE_T: o_stall = 1'b0;
            default:           o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pid_pkg::S_IDLE_T;
            r_mode      <= 1'b0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_alpha     <= 17'h10000;
            r_olim      <= '0;
            r_ilim      <= '0;
            r_prev_err  <= '0;
            r_prev2_err <= '0;
            r_esum      <= '0;
            r_prev_d    <= '0;
            r_held      <= '0;
            r_op        <= pid_pkg::OP_P;
            r_cnt       <= '0;
            o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (pid_pkg::t_reg'(cfg_idx))
                    pid_pkg::REG_MODE:    r_mode   <= pwdata[0];
                    pid_pkg::REG_GAIN_P:  r_gain_p <= pwdata[23:0];
                    pid_pkg::REG_GAIN_I:  r_gain_i <= pwdata[23:0];
                    pid_pkg::REG_GAIN_D:  r_gain_d <= pwdata[23:0];
                    pid_pkg::REG_D_ALPHA: r_alpha  <= pwdata[16:0];
                    pid_pkg::REG_OUT_LIM: r_olim   <= pwdata[30:0];
                    pid_pkg::REG_INT_LIM: r_ilim   <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall && (r_state != pid_pkg::S_OUT_T)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                pid_pkg::S_IDLE_T: begin
                    if (in_acc) begin
                        r_op <= pid_pkg::OP_P;
                        if (i_cmd == pid_pkg::CMD_CLEAR) begin
                            r_prev_err  <= '0;
                            r_prev2_err <= '0;
                            r_esum      <= '0;
                            r_prev_d    <= '0;
                            r_held      <= '0;
                            r_p         <= '0;
                            r_i         <= '0;
                            r_d         <= '0;
                            r_o         <= '0;
                        end else if (!r_mode) begin
                            r_esum     <= esum_new;
                            r_e1       <= OW'(err);
                            r_e2       <= OW'(esum_new);
                            r_e3       <= OW'(err) - OW'(r_prev_err);
                            r_prev_err <= err;
                        end else begin
                            r_e1        <= OW'(err) - OW'(r_prev_err);
                            r_e2        <= OW'(err);
                            r_e3        <= OW'(err) - (OW'(r_prev_err) <<< 1)
                                           + OW'(r_prev2_err);
                            r_prev2_err <= r_prev_err;
                            r_prev_err  <= err;
                        end
                    end
                end
                pid_pkg::S_LOAD_T: begin
                    r_cnt <= '0;
                    case (r_op)
                        pid_pkg::OP_P: begin
                            r_acc   <= {(OW+1)'(0), r_gain_p};
                            r_mcand <= r_e1;
                        end
                        pid_pkg::OP_I: begin
                            r_acc   <= {(OW+1)'(0), r_gain_i};
                            r_mcand <= r_e2;
                        end
                        pid_pkg::OP_D: begin
                            r_acc   <= {(OW+1)'(0), r_gain_d};
                            r_mcand <= r_e3;
                        end
                        default: begin
                            r_acc   <= {(OW+1)'(0), 7'd0, r_alpha};
                            r_mcand <= OW'(r_raw) - OW'(r_prev_d);
                        end
                    endcase
                end
                pid_pkg::S_MUL_T: begin
                    r_acc <= prod;
                    r_cnt <= r_cnt + 5'd1;
                    if (mul_last) begin
                        r_op <= pid_pkg::t_op'(r_op + 2'd1);
                        // take the finished product straight from the last step
                        case (r_op)
                            pid_pkg::OP_P: r_p   <= pid_pkg::sat32(prod);
                            pid_pkg::OP_I: r_i   <= pid_pkg::sat32(prod);
                            pid_pkg::OP_D: r_raw <= pid_pkg::sat32(prod);
                            default: begin
                                r_d      <= d_new;
                                r_prev_d <= d_new;
                            end
                        endcase
                    end
                end
                pid_pkg::S_SUM_T: begin
                    r_o    <= o_new;
                    r_held <= o_new;
                end
                pid_pkg::S_OUT_T: begin
                    if (out_free) begin
                        o_valid  <= 1'b1;
                        o_drive  <= r_o;
                        o_p_term <= r_p;
                        o_i_term <= r_i;
                        o_d_term <= r_d;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/pid_chk.sv
`default_nettype none
module pid_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_drive,
    input wire logic        pready
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_drive)) else $error("stalled drive changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("not busy after a transaction");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)) else $error("result without work");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");

endmodule

bind pid_controller_dual_form pid_chk u_pid_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_drive (o_drive),
    .pready  (pready)
);
`default_nettype wire
